/* design/mrrb_pkg.sv */
// Package for the multi-stream round-robin batcher.
// Holds request kinds, result type codes, and shared widths and types.
// No dependencies.
package mrrb_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_NUM_STREAMS = 8;
  localparam int DEF_MAX_DEPTH   = 16;
  localparam int DEF_MAX_BATCH   = 16;

  // Queue entry is {frame tag, capture time}.
  localparam int TAG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = TAG_W + TIME_W;
  localparam int CNT_W   = 32;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_BATCH   = 2'd1;
  localparam logic [1:0] REG_WAIT    = 2'd2;
  localparam logic [1:0] REG_QLIMIT  = 2'd3;

  // Request kinds.
  localparam logic [2:0] KIND_FRAME = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_DROPS = 3'd3;
  localparam logic [2:0] KIND_HIST  = 3'd4;

  // Result types.
  localparam logic [1:0] RES_ENQ    = 2'd0;
  localparam logic [1:0] RES_MEMBER = 2'd1;
  localparam logic [1:0] RES_DROPS  = 2'd2;
  localparam logic [1:0] RES_HIST   = 2'd3;

  // Control from the sequencer to the statistics counters.
  typedef struct packed {
    logic       drop_inc;
    logic       hist_inc;
    logic [7:0] stream_idx;
    logic [7:0] bin_idx;
  } stat_ctl_t;

endpackage

/* design/mrrb_qmem.sv */
// Queue storage for all streams: one write port and one registered read port.
// Depends on mrrb_pkg for the entry width.
module mrrb_qmem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [mrrb_pkg::ENTRY_W-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [mrrb_pkg::ENTRY_W-1:0] rd_data
);
  import mrrb_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

/* design/mrrb_stats.sv */
// Saturating drop counters per stream and the batch size histogram.
// Depends on mrrb_pkg for the control struct and counter width.
module mrrb_stats #(
  parameter int NUM_STREAMS = 8,
  parameter int MAX_BATCH   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mrrb_pkg::stat_ctl_t      ctl,
  output logic [mrrb_pkg::CNT_W-1:0] drop_val,
  output logic [mrrb_pkg::CNT_W-1:0] hist_val
);
  import mrrb_pkg::*;

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int HW = $clog2(MAX_BATCH + 1);

  logic [CNT_W-1:0] drops_r [NUM_STREAMS];
  logic [CNT_W-1:0] hist_r  [MAX_BATCH+1];
  logic             s_ok;
  logic             b_ok;

  assign s_ok = 32'(ctl.stream_idx) < NUM_STREAMS;
  assign b_ok = 32'(ctl.bin_idx) <= MAX_BATCH;

  // Counters clear on reset and stick at all ones.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STREAMS; i++) drops_r[i] <= '0;
      for (int i = 0; i <= MAX_BATCH; i++) hist_r[i] <= '0;
    end else begin
      if (ctl.drop_inc && s_ok && drops_r[ctl.stream_idx[SW-1:0]] != '1) begin
        drops_r[ctl.stream_idx[SW-1:0]] <= drops_r[ctl.stream_idx[SW-1:0]] + 1'b1;
      end
      if (ctl.hist_inc && b_ok && hist_r[ctl.bin_idx[HW-1:0]] != '1) begin
        hist_r[ctl.bin_idx[HW-1:0]] <= hist_r[ctl.bin_idx[HW-1:0]] + 1'b1;
      end
    end
  end

  // Out-of-range reads give zero.
  assign drop_val = s_ok ? drops_r[ctl.stream_idx[SW-1:0]] : '0;
  assign hist_val = b_ok ? hist_r[ctl.bin_idx[HW-1:0]] : '0;
endmodule

/* design/multi_stream_round_robin_batcher_unit.sv */
// Multi-stream round-robin batcher: per-stream frame queues, timeout batching.
// Sequence: a request is taken while idle and decoded; a frame or counter read then loads its
// result into the output register. A frame or tick then scans the active streams (S_SC_ADDR,
// plus S_SC_DATA for a non-empty one), decides, aligns the rotating pointer by wrap steps, and
// emits each member through S_GA_ADDR and S_GA_DATA, skipping empty streams; output stalls hold it.
// The block takes one request at a time. Reset (synchronous, rst_n low) empties queues and counters.
module multi_stream_round_robin_batcher_unit #(
  parameter int NUM_STREAMS = mrrb_pkg::DEF_NUM_STREAMS,
  parameter int MAX_DEPTH   = mrrb_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BATCH   = mrrb_pkg::DEF_MAX_BATCH,
  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1,
  localparam int BW = $clog2(MAX_BATCH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [3:0]    in_stream,
  input  logic [15:0]   in_frame_tag,
  input  logic [31:0]   in_time_ms,
  input  logic          in_discard,
  input  logic [4:0]    in_bin,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_result_type,
  output logic          out_accepted,
  output logic          out_dropped_oldest,
  output logic [SW-1:0] out_member_stream,
  output logic [15:0]   out_member_tag,
  output logic [31:0]   out_member_time,
  output logic [BW-1:0] out_batch_count,
  output logic          out_last,
  output logic [31:0]   out_stat_value
);
  import mrrb_pkg::*;

  localparam int SCW   = $clog2(NUM_STREAMS + 1);
  localparam int DW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FW    = $clog2(MAX_DEPTH + 1);
  localparam int QD    = NUM_STREAMS * MAX_DEPTH;
  localparam int AW    = (QD > 1) ? $clog2(QD) : 1;
  localparam int TW    = $clog2(QD + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_FRAME, S_SC_ADDR, S_SC_DATA, S_DECIDE, S_MOD,
    S_GA_ADDR, S_GA_DATA, S_READ
  } state_t;

  state_t            state_r;
  logic [3:0]        act_r;
  logic [4:0]        blim_r;
  logic [15:0]       wait_r;
  logic [4:0]        qlim_r;
  logic [2:0]        kind_r;
  logic [7:0]        stream_r;
  logic [15:0]       tag_r;
  logic [31:0]       time_r;
  logic              discard_r;
  logic [7:0]        bin_r;
  logic [DW-1:0]     head_r [NUM_STREAMS];
  logic [FW-1:0]     fill_r [NUM_STREAMS];
  logic [31:0]       cur_time_r;
  logic              stopped_r;
  logic [SCW-1:0]    sp_r;
  logic [SCW-1:0]    s_r;
  logic [TW-1:0]     total_r;
  logic [32:0]       min_dl_r;
  logic [BW-1:0]     take_r;
  logic [BW-1:0]     cnt_r;
  logic [SW-1:0]     ms_r;

  logic              out_valid_r;
  logic [1:0]        out_type_r;
  logic              out_acc_r;
  logic              out_drp_r;
  logic [SW-1:0]     out_ms_r;
  logic [15:0]       out_tag_r;
  logic [31:0]       out_time_r;
  logic [BW-1:0]     out_cnt_r;
  logic              out_last_r;
  logic [31:0]       out_stat_r;

  logic [8:0]        n_c, b_c, dep_c;
  logic [SCW-1:0]    n_s;
  logic              out_free;
  logic              out_load;
  logic [SW-1:0]     sel;
  logic [DW-1:0]     head_cur;
  logic [FW-1:0]     fill_cur;
  logic              frame_ok;
  logic              full_c;
  logic [DW-1:0]     head_inc;
  logic [DW-1:0]     head_new;
  logic [FW-1:0]     fill_new;
  logic [DW+FW:0]    pos_sum;
  logic [DW-1:0]     pos_c;
  logic              go_c;
  logic [BW-1:0]     take_c;
  logic [SCW-1:0]    s_next;
  logic [32:0]       dl_c;
  logic              qwr_en, qrd_en;
  logic [AW-1:0]     qwr_addr, qrd_addr;
  logic [ENTRY_W-1:0] qrd_data;
  stat_ctl_t         sctl;
  logic [31:0]       drop_val, hist_val;

  // Clamped configuration.
  always_comb begin
    n_c   = (act_r == '0) ? 9'd1 : (32'(act_r) > NUM_STREAMS) ? 9'(NUM_STREAMS) : 9'(act_r);
    b_c   = (blim_r == '0) ? 9'd1 : (32'(blim_r) > MAX_BATCH) ? 9'(MAX_BATCH) : 9'(blim_r);
    dep_c = (qlim_r == '0) ? 9'd1 : (32'(qlim_r) > MAX_DEPTH) ? 9'(MAX_DEPTH) : 9'(qlim_r);
    n_s   = SCW'(n_c);
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // The output register takes a new result in these states once it is free.
  assign out_load = out_free &&
                    ((state_r == S_FRAME) || (state_r == S_GA_DATA) || (state_r == S_READ));

  // Queue pointers of the stream under work.
  assign sel      = (state_r == S_FRAME) ? stream_r[SW-1:0] : s_r[SW-1:0];
  assign head_cur = head_r[sel];
  assign fill_cur = fill_r[sel];
  assign head_inc = (32'(head_cur) + 1 == MAX_DEPTH) ? '0 : DW'(32'(head_cur) + 1);
  assign s_next   = (s_r + 1'b1 == n_s) ? '0 : s_r + 1'b1;

  // Enqueue: evict on a full queue, then write behind the tail.
  always_comb begin
    frame_ok = !stopped_r && (9'(stream_r) < n_c);
    full_c   = 9'(fill_cur) >= dep_c;
    head_new = full_c ? head_inc : head_cur;
    fill_new = full_c ? fill_cur - 1'b1 : fill_cur;
    pos_sum  = (DW+FW+1)'(head_new) + (DW+FW+1)'(fill_new);
    pos_c    = (32'(pos_sum) >= MAX_DEPTH) ? DW'(32'(pos_sum) - MAX_DEPTH) : DW'(pos_sum);
  end

  // Batch decision after the scan.
  always_comb begin
    go_c   = !stopped_r && (total_r != '0) &&
             ((wait_r == '0) || (32'(total_r) >= 32'(b_c)) || ({1'b0, cur_time_r} >= min_dl_r));
    take_c = (32'(total_r) < 32'(b_c)) ? BW'(total_r) : BW'(b_c);
    dl_c   = {1'b0, qrd_data[TIME_W-1:0]} + 33'(wait_r);
  end

  // Queue memory ports.
  always_comb begin
    qwr_en   = (state_r == S_FRAME) && out_free && frame_ok;
    qwr_addr = AW'(32'(sel) * MAX_DEPTH + 32'(pos_c));
    qrd_en   = ((state_r == S_SC_ADDR) && (s_r < n_s) && (fill_cur != '0)) ||
               ((state_r == S_GA_ADDR) && (fill_cur != '0));
    qrd_addr = AW'(32'(sel) * MAX_DEPTH + 32'(head_cur));
  end

  // Statistics control.
  always_comb begin
    sctl.drop_inc   = qwr_en && full_c;
    sctl.hist_inc   = (state_r == S_DECIDE) && go_c;
    sctl.stream_idx = stream_r;
    sctl.bin_idx    = (state_r == S_DECIDE) ? 8'(take_c) : bin_r;
  end

  mrrb_qmem #(.DEPTH(QD), .AW(AW)) u_qmem (
    .clk     (clk),
    .wr_en   (qwr_en),
    .wr_addr (qwr_addr),
    .wr_data ({tag_r, time_r}),
    .rd_en   (qrd_en),
    .rd_addr (qrd_addr),
    .rd_data (qrd_data)
  );

  mrrb_stats #(.NUM_STREAMS(NUM_STREAMS), .MAX_BATCH(MAX_BATCH)) u_stats (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .drop_val (drop_val),
    .hist_val (hist_val)
  );

  // Sequencer, queue pointers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= 4'd8;
      blim_r      <= 5'd4;
      wait_r      <= 16'd33;
      qlim_r      <= 5'd4;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
      cur_time_r  <= '0;
      stopped_r   <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE: act_r  <= cfg_wdata[3:0];
          REG_BATCH:  blim_r <= cfg_wdata[4:0];
          REG_WAIT:   wait_r <= cfg_wdata;
          REG_QLIMIT: qlim_r <= cfg_wdata[4:0];
        endcase
      end

      // Output valid: set on a new result, cleared when the result is taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_kind;
            stream_r  <= 8'(in_stream);
            tag_r     <= in_frame_tag;
            time_r    <= in_time_ms;
            discard_r <= in_discard;
            bin_r     <= 8'(in_bin);
            state_r   <= S_DEC;
          end
        end
        S_DEC: begin
          s_r      <= '0;
          total_r  <= '0;
          min_dl_r <= '1;
          priority if (kind_r == KIND_FRAME) begin
            state_r <= S_FRAME;
          end else if (kind_r == KIND_TICK) begin
            cur_time_r <= time_r;
            state_r    <= S_SC_ADDR;
          end else if (kind_r == KIND_STOP) begin
            stopped_r <= 1'b1;
            if (discard_r) begin
              for (int i = 0; i < NUM_STREAMS; i++) begin
                head_r[i] <= '0;
                fill_r[i] <= '0;
              end
            end
            state_r <= S_IDLE;
          end else if (kind_r == KIND_DROPS || kind_r == KIND_HIST) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FRAME: begin
          if (out_free) begin
            if (frame_ok) begin
              head_r[sel] <= head_new;
              fill_r[sel] <= fill_new + 1'b1;
            end
            out_type_r  <= RES_ENQ;
            out_acc_r   <= frame_ok;
            out_drp_r   <= frame_ok && full_c;
            out_ms_r    <= '0;
            out_tag_r   <= '0;
            out_time_r  <= '0;
            out_cnt_r   <= '0;
            out_last_r  <= 1'b0;
            out_stat_r  <= '0;
            state_r     <= S_SC_ADDR;
          end
        end
        // Scan: total fill and earliest head deadline, one stream at a time.
        S_SC_ADDR: begin
          if (s_r >= n_s) begin
            state_r <= S_DECIDE;
          end else if (fill_cur != '0) begin
            total_r <= total_r + TW'(fill_cur);
            state_r <= S_SC_DATA;
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        S_SC_DATA: begin
          if (dl_c < min_dl_r) min_dl_r <= dl_c;
          s_r     <= s_r + 1'b1;
          state_r <= S_SC_ADDR;
        end
        S_DECIDE: begin
          take_r  <= take_c;
          state_r <= go_c ? S_MOD : S_IDLE;
        end
        // Reduce the rotating pointer into the active stream range.
        S_MOD: begin
          if (sp_r >= n_s) begin
            sp_r <= sp_r - n_s;
          end else begin
            s_r     <= sp_r;
            sp_r    <= (sp_r + 1'b1 == n_s) ? '0 : sp_r + 1'b1;
            cnt_r   <= '0;
            state_r <= S_GA_ADDR;
          end
        end
        // Gather: visit streams cyclically, pop one head per non-empty stream.
        S_GA_ADDR: begin
          if (fill_cur != '0) begin
            head_r[sel] <= head_inc;
            fill_r[sel] <= fill_cur - 1'b1;
            ms_r        <= sel;
            state_r     <= S_GA_DATA;
          end else begin
            s_r <= s_next;
          end
        end
        S_GA_DATA: begin
          if (out_free) begin
            out_type_r  <= RES_MEMBER;
            out_acc_r   <= 1'b0;
            out_drp_r   <= 1'b0;
            out_ms_r    <= ms_r;
            out_tag_r   <= qrd_data[ENTRY_W-1:TIME_W];
            out_time_r  <= qrd_data[TIME_W-1:0];
            out_cnt_r   <= take_r;
            out_last_r  <= (cnt_r + 1'b1 == take_r);
            out_stat_r  <= '0;
            cnt_r       <= cnt_r + 1'b1;
            s_r         <= s_next;
            state_r     <= (cnt_r + 1'b1 == take_r) ? S_IDLE : S_GA_ADDR;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_type_r  <= (kind_r == KIND_DROPS) ? RES_DROPS : RES_HIST;
            out_acc_r   <= 1'b0;
            out_drp_r   <= 1'b0;
            out_ms_r    <= '0;
            out_tag_r   <= '0;
            out_time_r  <= '0;
            out_cnt_r   <= '0;
            out_last_r  <= 1'b0;
            out_stat_r  <= (kind_r == KIND_DROPS) ? drop_val : hist_val;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_type    = out_type_r;
  assign out_accepted       = out_acc_r;
  assign out_dropped_oldest = out_drp_r;
  assign out_member_stream  = out_ms_r;
  assign out_member_tag     = out_tag_r;
  assign out_member_time    = out_time_r;
  assign out_batch_count    = out_cnt_r;
  assign out_last           = out_last_r;
  assign out_stat_value     = out_stat_r;
endmodule

/* bench/multi_stream_round_robin_batcher_unit_tb.sv */
// Testbench for the multi-stream round-robin batcher: directed and random requests.
// A scoreboard class predicts enqueue responses, batches and counter reads.
// Depends on mrrb_pkg and multi_stream_round_robin_batcher_unit.
module multi_stream_round_robin_batcher_unit_tb;
  import mrrb_pkg::*;

  localparam int NS = DEF_NUM_STREAMS;
  localparam int MD = DEF_MAX_DEPTH;
  localparam int MB = DEF_MAX_BATCH;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  rtype;
    logic        acc;
    logic        drp;
    logic [2:0]  mstream;
    logic [15:0] mtag;
    logic [31:0] mtime;
    logic [4:0]  cnt;
    logic        last;
    logic [31:0] stat;
  } batch_result_t;

  // Scoreboard: own copy of the batcher state and the expected result queue.
  class batcher_scoreboard;
    logic [15:0] tag_mem [NS*MD];
    logic [31:0] time_mem [NS*MD];
    int unsigned head [NS];
    int unsigned fill [NS];
    logic [31:0] drops [NS];
    logic [31:0] hist [MB+1];
    int unsigned rr_ptr;
    logic [31:0] now_ms;
    bit halted;
    int unsigned n_active, b_limit, w_time, q_limit;
    batch_result_t pending [$];
    int errors;
    int batches;

    function new();
      errors = 0;
      batches = 0;
      for (int s = 0; s < NS; s++) begin
        head[s] = 0; fill[s] = 0; drops[s] = 0;
      end
      for (int b = 0; b <= MB; b++) hist[b] = 0;
      rr_ptr = 0; now_ms = 0; halted = 0;
      n_active = 8; b_limit = 4; w_time = 33; q_limit = 4;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_ACTIVE: n_active = 32'(val[3:0]);
        REG_BATCH:  b_limit = 32'(val[4:0]);
        REG_WAIT:   w_time = 32'(val);
        REG_QLIMIT: q_limit = 32'(val[4:0]);
        default: ;
      endcase
    endfunction

    function batch_result_t blank();
      batch_result_t r;
      r = '0;
      return r;
    endfunction

    // Decide whether a batch is due and, if so, gather it round by round.
    function void gather_batch();
      int unsigned n, b, total, start, taken, s;
      longint unsigned deadline, d;
      batch_result_t members [$];
      batch_result_t r;
      n = clamp(n_active, NS);
      b = clamp(b_limit, MB);
      total = 0;
      deadline = 64'hFFFF_FFFF_FFFF_FFFF;
      if (halted) return;
      for (s = 0; s < n; s++) begin
        total += fill[s];
        if (fill[s] != 0) begin
          d = 64'(time_mem[s*MD + head[s]]) + 64'(w_time);
          if (d < deadline) deadline = d;
        end
      end
      if (total == 0) return;
      if (!(w_time == 0 || total >= b || 64'(now_ms) >= deadline)) return;
      start = rr_ptr % n;
      rr_ptr = (start + 1) % n;
      taken = 0;
      while (taken < b && taken < total) begin
        for (int i = 0; i < n && taken < b; i++) begin
          s = (start + i) % n;
          if (fill[s] != 0) begin
            r = blank();
            r.rtype = RES_MEMBER;
            r.mstream = 3'(s);
            r.mtag = tag_mem[s*MD + head[s]];
            r.mtime = time_mem[s*MD + head[s]];
            members = {members, r};
            taken++;
            head[s] = (head[s] + 1) % MD;
            fill[s]--;
          end
        end
      end
      if (hist[taken] != 32'hFFFF_FFFF) hist[taken]++;
      batches++;
      foreach (members[i]) begin
        members[i].cnt = 5'(taken);
        members[i].last = (i == int'(taken) - 1);
        pending = {pending, members[i]};
      end
    endfunction

    // Note an accepted request and queue whatever it should produce.
    function void note_request(logic [2:0] kind, logic [3:0] stream, logic [15:0] tag,
                               logic [31:0] tms, logic discard, logic [4:0] bin);
      batch_result_t r;
      int unsigned n, depth, pos;
      n = clamp(n_active, NS);
      depth = clamp(q_limit, MD);
      r = blank();
      case (kind)
        KIND_FRAME: begin
          r.rtype = RES_ENQ;
          if (!halted && 32'(stream) < n) begin
            r.acc = 1'b1;
            if (fill[stream] >= depth) begin
              head[stream] = (head[stream] + 1) % MD;
              fill[stream]--;
              if (drops[stream] != 32'hFFFF_FFFF) drops[stream]++;
              r.drp = 1'b1;
            end
            pos = (head[stream] + fill[stream]) % MD;
            tag_mem[32'(stream)*MD + pos] = tag;
            time_mem[32'(stream)*MD + pos] = tms;
            fill[stream]++;
          end
          pending = {pending, r};
          gather_batch();
        end
        KIND_TICK: begin
          now_ms = tms;
          gather_batch();
        end
        KIND_STOP: begin
          halted = 1;
          if (discard) begin
            for (int s = 0; s < NS; s++) begin
              head[s] = 0; fill[s] = 0;
            end
          end
        end
        KIND_DROPS: begin
          r.rtype = RES_DROPS;
          r.stat = (32'(stream) < NS) ? drops[stream] : '0;
          pending = {pending, r};
        end
        KIND_HIST: begin
          r.rtype = RES_HIST;
          r.stat = (32'(bin) <= MB) ? hist[bin] : '0;
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(batch_result_t got);
      batch_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result type=%0d tag=%0h", got.rtype, got.mtag);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.rtype !== want.rtype) begin
        $error("result_type exp %0d got %0d", want.rtype, got.rtype); errors++;
      end
      if (got.acc !== want.acc) begin
        $error("accepted exp %0d got %0d", want.acc, got.acc); errors++;
      end
      if (got.drp !== want.drp) begin
        $error("dropped_oldest exp %0d got %0d", want.drp, got.drp); errors++;
      end
      if (got.mstream !== want.mstream) begin
        $error("member_stream exp %0d got %0d", want.mstream, got.mstream); errors++;
      end
      if (got.mtag !== want.mtag) begin
        $error("member_tag exp %0h got %0h", want.mtag, got.mtag); errors++;
      end
      if (got.mtime !== want.mtime) begin
        $error("member_time exp %0h got %0h", want.mtime, got.mtime); errors++;
      end
      if (got.cnt !== want.cnt) begin
        $error("batch_count exp %0d got %0d", want.cnt, got.cnt); errors++;
      end
      if (got.last !== want.last) begin
        $error("last exp %0d got %0d", want.last, got.last); errors++;
      end
      if (got.stat !== want.stat) begin
        $error("stat_value exp %0h got %0h", want.stat, got.stat); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_ACTIVE;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_kind = KIND_FRAME;
  logic [3:0] in_stream = '0;
  logic [15:0] in_frame_tag = '0;
  logic [31:0] in_time_ms = '0;
  logic in_discard = 0;
  logic [4:0] in_bin = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_result_type;
  logic out_accepted, out_dropped_oldest, out_last;
  logic [2:0] out_member_stream;
  logic [15:0] out_member_tag;
  logic [31:0] out_member_time, out_stat_value;
  logic [4:0] out_batch_count;

  batcher_scoreboard sb;
  int cycles = 0;
  int sent = 0;
  int stall_mode = 0;
  logic [31:0] clock_ms = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  multi_stream_round_robin_batcher_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_stream(in_stream), .in_frame_tag(in_frame_tag), .in_time_ms(in_time_ms),
    .in_discard(in_discard), .in_bin(in_bin),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_type(out_result_type),
    .out_accepted(out_accepted), .out_dropped_oldest(out_dropped_oldest),
    .out_member_stream(out_member_stream), .out_member_tag(out_member_tag),
    .out_member_time(out_member_time), .out_batch_count(out_batch_count),
    .out_last(out_last), .out_stat_value(out_stat_value)
  );

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: the stall pattern is chosen at random among none, light and heavy.
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Check every accepted result.
  always @(posedge clk) begin
    batch_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.rtype = out_result_type;
      got.acc = out_accepted;
      got.drp = out_dropped_oldest;
      got.mstream = out_member_stream;
      got.mtag = out_member_tag;
      got.mtime = out_member_time;
      got.cnt = out_batch_count;
      got.last = out_last;
      got.stat = out_stat_value;
      sb.check_result(got);
    end
  end

  // Present one request and hold it until the handshake.
  task automatic send(logic [2:0] kind, logic [3:0] stream, logic [15:0] tag,
                      logic [31:0] tms, logic discard, logic [4:0] bin);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_stream <= stream;
    in_frame_tag <= tag;
    in_time_ms <= tms;
    in_discard <= discard;
    in_bin <= bin;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, stream, tag, tms, discard, bin);
    sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Wait until all expectations are met, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(int act, int bl, int wt, int ql);
    write_cfg(REG_ACTIVE, 16'(act));
    write_cfg(REG_BATCH, 16'(bl));
    write_cfg(REG_WAIT, 16'(wt));
    write_cfg(REG_QLIMIT, 16'(ql));
  endtask

  // Random phase: mostly frames on streams 0 to 9 and ticks with advancing time.
  task automatic random_phase(int count);
    int burst;
    int k;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 20);
      if (k < 62)
        send(KIND_FRAME, 4'($urandom_range(0, 9)), 16'($urandom),
             clock_ms + $urandom_range(0, 8), 1'($urandom_range(0, 1)), 5'($urandom));
      else if (k < 82)
        send(KIND_TICK, 4'($urandom), 16'($urandom), clock_ms,
             1'($urandom_range(0, 1)), 5'($urandom));
      else if (k < 88)
        send(KIND_FRAME, 4'($urandom), 16'($urandom), $urandom,
             1'($urandom_range(0, 1)), 5'($urandom));
      else if (k < 93)
        send(KIND_DROPS, 4'($urandom), 16'($urandom), $urandom,
             1'($urandom_range(0, 1)), 5'($urandom));
      else if (k < 98)
        send(KIND_HIST, 4'($urandom), 16'($urandom), $urandom,
             1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
      else
        send(3'($urandom_range(5, 7)), 4'($urandom), 16'($urandom), $urandom, 1'b0,
             5'($urandom));
      if (--burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default config, fill queues, overflow, timeout, extremes.
    send(KIND_FRAME, 4'd0, 16'h0000, 32'd10, 1'b0, 5'd0);
    send(KIND_TICK, 4'd0, 16'd0, 32'd42, 1'b0, 5'd0);
    send(KIND_TICK, 4'd0, 16'd0, 32'd43, 1'b0, 5'd0);
    for (int i = 0; i < 6; i++)
      send(KIND_FRAME, 4'd3, 16'hFFFF - 16'(i), 32'hFFFF_FF00 + 32'(i), 1'b1, 5'h1F);
    send(KIND_FRAME, 4'hF, 16'h1234, 32'h0, 1'b0, 5'd0);
    send(KIND_FRAME, 4'd8, 16'h1234, 32'h0, 1'b0, 5'd0);
    send(KIND_TICK, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 5'h1F);
    send(KIND_DROPS, 4'd3, 16'd0, 32'd0, 1'b0, 5'd0);
    send(KIND_DROPS, 4'hF, 16'd0, 32'd0, 1'b0, 5'd0);
    send(KIND_HIST, 4'd0, 16'd0, 32'd0, 1'b0, 5'd4);
    send(KIND_HIST, 4'd0, 16'd0, 32'd0, 1'b0, 5'd16);
    send(KIND_HIST, 4'd0, 16'd0, 32'd0, 1'b0, 5'h1F);
    send(3'd7, 4'd0, 16'd0, 32'd0, 1'b0, 5'd0);
    drain();

    // Extremes and out-of-range register values.
    set_config(0, 0, 0, 0);
    send(KIND_FRAME, 4'd0, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, 5'd0);
    send(KIND_FRAME, 4'd1, 16'hA5A6, 32'd1, 1'b0, 5'd0);
    drain();
    set_config(15, 31, 65535, 31);
    for (int i = 0; i < 18; i++) send(KIND_FRAME, 4'(i % 8), 16'(i), 32'(i), 1'b0, 5'd0);
    send(KIND_TICK, 4'd0, 16'd0, 32'd70000, 1'b0, 5'd0);
    drain();

    // Random phases over several settings.
    set_config(8, 4, 33, 4);
    random_phase(55);
    drain();
    set_config(3, 5, 10, 2);
    random_phase(50);
    drain();
    set_config(1, 1, 0, 1);
    random_phase(35);
    drain();
    set_config(8, 16, 40, 16);
    random_phase(50);
    drain();
    set_config(5, 7, 65535, 3);
    random_phase(30);
    // Shrink queue limit over full queues.
    drain();
    write_cfg(REG_QLIMIT, 16'd1);
    random_phase(15);
    send(KIND_STOP, 4'd0, 16'd0, 32'd0, 1'b0, 5'd0);
    send(KIND_FRAME, 4'd0, 16'd1, 32'd1, 1'b0, 5'd0);
    send(KIND_TICK, 4'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send(KIND_STOP, 4'd0, 16'd0, 32'd0, 1'b1, 5'd0);
    for (int b = 0; b <= MB; b++) send(KIND_HIST, 4'd0, 16'd0, 32'd0, 1'b0, 5'(b));
    for (int s = 0; s < NS; s++) send(KIND_DROPS, 4'(s), 16'd0, 32'd0, 1'b0, 5'd0);
    drain();

    $display("Covered %0d requests and %0d batches over default, clamped and random settings,",
             sent, sb.batches);
    $display("ending with stop, discard and a full readback of the counters.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
